FILE: hdl/trrea_pkg.sv
// Shared types and constants for the two-level round-robin eject arbiter.
`default_nettype none

package trrea_pkg;

    // Beat field and config register widths
    localparam int NODE_W   = 6;
    localparam int MASK_W   = 16;
    localparam int SUBNET_W = 2;
    localparam int VC_W     = 2;
    localparam int CFG_W    = 3;

    // Register index, taken from paddr[2]
    typedef enum logic {
        REG_ACTIVE_SUBNETS = 1'b0,
        REG_ACTIVE_VCS     = 1'b1
    } trrea_reg_t;

    // Outcome of one arbitration
    typedef struct packed {
        logic                granted;
        logic [SUBNET_W-1:0] win_subnet;
        logic [VC_W-1:0]     win_vc;
    } trrea_result_t;

endpackage

`default_nettype wire

FILE: hdl/two_level_round_robin_eject_arbiter.sv
// Top level of the two-level round-robin eject arbiter.
// Usage:
//   s_ channel: one beat is one pop request: node index and a pending mask
//   with bit subnet*MAX_VCS+vc set for each buffer that holds a packet.
//   m_ channel: one result beat per request: granted flag, winning subnet
//   and VC (both zero when nothing was granted).
//   APB port: register 0 (addr 0) active subnet count, register 1 (addr 4)
//   active VC count; user must write only while the arbiter is idle, not enforced.
// Timing:
//   An accepted s_ beat passes the search stage and result register to
//   m_tvalid. One beat per cycle sustained while m_tready is high: the node's
//   pointer row is read from the pointer RAM on accept, searched and written
//   back on advance; a request for the node just served uses the bypass register.
// Reset:
//   aresetn clears control state, then a clearing pass writes zero pointers
//   to every node row with s_tready low. APB stays usable.
// Backpressure:
//   When m_tready is low the result register holds, one more request can
//   sit in the search stage, and then s_tready drops.
`default_nettype none

module two_level_round_robin_eject_arbiter import trrea_pkg::*; #(
    parameter int MAX_SUBNETS = 4,
    parameter int MAX_VCS     = 4,
    parameter int NODES       = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request beats
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [5:0] node, [21:6] pending_mask, rest zero
    // result beats
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [0] granted, [2:1] win_subnet, [4:3] win_vc
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int SPW   = (MAX_SUBNETS > 1) ? $clog2(MAX_SUBNETS) : 1;
    localparam int VPW   = (MAX_VCS > 1) ? $clog2(MAX_VCS) : 1;
    localparam int ROW_W = SPW + MAX_SUBNETS * VPW;
    localparam int AW    = $clog2(NODES);

    // config registers
    logic [CFG_W-1:0] active_subnets_reg;
    logic [CFG_W-1:0] active_vcs_reg;
    logic             cfg_wr;

    // clearing pass
    logic             clr_busy_reg;
    logic [AW-1:0]    clr_addr_reg;

    // search stage
    logic              s1_valid_reg;
    logic [NODE_W-1:0] s1_node_reg;
    logic [MASK_W-1:0] s1_mask_reg;
    logic              fwd_hit_reg;
    logic [ROW_W-1:0]  fwd_row_reg;

    // result register
    logic              m_valid_reg;
    trrea_result_t     m_data_reg;

    logic              accept;
    logic              out_ready;
    logic              s1_advance;
    logic              item_wr;
    logic [NODE_W-1:0] s_node;
    logic [MASK_W-1:0] s_mask;
    logic              node_ok;
    logic [ROW_W-1:0]  ram_rdata;
    logic [ROW_W-1:0]  row_cur;
    logic [ROW_W-1:0]  row_new;
    trrea_result_t     res;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [ROW_W-1:0]  ram_wdata;

    assign s_node = s_tdata[NODE_W-1:0];
    assign s_mask = s_tdata[NODE_W +: MASK_W];

    //------------------------------------------------------------------
    // APB: zero-wait, register picked by paddr[2]
    //------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_subnets_reg <= CFG_W'(2);
            active_vcs_reg     <= CFG_W'(4);
        end else if (cfg_wr) begin
            unique case (trrea_reg_t'(paddr[2]))
                REG_ACTIVE_SUBNETS: active_subnets_reg <= pwdata[CFG_W-1:0];
                REG_ACTIVE_VCS:     active_vcs_reg     <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (trrea_reg_t'(paddr[2]))
            REG_ACTIVE_SUBNETS: prdata = {{(32-CFG_W){1'b0}}, active_subnets_reg};
            REG_ACTIVE_VCS:     prdata = {{(32-CFG_W){1'b0}}, active_vcs_reg};
            default:            prdata = '0;
        endcase
    end

    //------------------------------------------------------------------
    // Handshake: one request in search, one result waiting
    //------------------------------------------------------------------
    assign out_ready  = !m_valid_reg || m_tready;
    assign s1_advance = s1_valid_reg && out_ready;
    assign s_tready   = !clr_busy_reg && (!s1_valid_reg || out_ready);
    assign accept     = s_tvalid && s_tready;

    // Clearing pass after reset: one row per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(NODES - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    //------------------------------------------------------------------
    // Pointer RAM: row = {vc pointers per subnet, subnet pointer}
    //------------------------------------------------------------------
    assign item_wr   = s1_advance && res.granted;
    assign ram_we    = clr_busy_reg || item_wr;
    assign ram_waddr = clr_busy_reg ? clr_addr_reg : AW'(s1_node_reg);
    assign ram_wdata = clr_busy_reg ? '0 : row_new;

    trrea_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NODES)
    ) u_ptr_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (AW'(s_node)),
        .rdata (ram_rdata)
    );

    // Search stage load; bypass catches a same-node write at the read edge
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_node_reg <= s_node;
            s1_mask_reg <= s_mask;
            fwd_hit_reg <= item_wr && (s1_node_reg == s_node);
            fwd_row_reg <= row_new;
        end
    end

    assign row_cur = fwd_hit_reg ? fwd_row_reg : ram_rdata;
    assign node_ok = (32'(s1_node_reg) < NODES);

    trrea_pick #(
        .MAX_SUBNETS (MAX_SUBNETS),
        .MAX_VCS     (MAX_VCS),
        .SPW         (SPW),
        .VPW         (VPW),
        .ROW_W       (ROW_W)
    ) u_pick (
        .active_subnets (active_subnets_reg),
        .active_vcs     (active_vcs_reg),
        .pending_mask   (s1_mask_reg),
        .node_ok        (node_ok),
        .row_in         (row_cur),
        .result         (res),
        .row_out        (row_new)
    );

    //------------------------------------------------------------------
    // Result register
    //------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            m_data_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_data_reg.win_vc, m_data_reg.win_subnet,
                       m_data_reg.granted};

    //------------------------------------------------------------------
    // Checks
    //------------------------------------------------------------------
    // no request is taken while pointer rows are being cleared
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> !s_tready)
        else $error("request accepted during clearing pass");

    // a request leaving the search stage shows up as a result beat
    a_advance_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_advance |=> m_valid_reg)
        else $error("search result lost");

    // out-of-range nodes are never granted and never write the RAM
    a_node_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !node_ok) |-> (!res.granted && !item_wr))
        else $error("grant for node out of range");

    // a same-node write at accept must set the bypass hit for the request in the stage
    a_fwd_write_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && item_wr && (s1_node_reg == s_node)) |=> fwd_hit_reg)
        else $error("same-node bypass missed");

endmodule

`default_nettype wire

FILE: hdl/trrea_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module trrea_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/trrea_pick.sv
// Two-level rotating priority search over one node's pending buffers.
`default_nettype none

module trrea_pick import trrea_pkg::*; #(
    parameter int MAX_SUBNETS = 4,
    parameter int MAX_VCS     = 4,
    parameter int SPW         = 2,
    parameter int VPW         = 2,
    parameter int ROW_W       = SPW + MAX_SUBNETS * VPW
) (
    input  wire logic [CFG_W-1:0]  active_subnets,
    input  wire logic [CFG_W-1:0]  active_vcs,
    input  wire logic [MASK_W-1:0] pending_mask,
    input  wire logic              node_ok,
    input  wire logic [ROW_W-1:0]  row_in,
    output trrea_result_t          result,
    output logic      [ROW_W-1:0]  row_out
);

    localparam int NS_W = $clog2(MAX_SUBNETS + 1);
    localparam int NV_W = $clog2(MAX_VCS + 1);

    logic [NS_W-1:0]    ns;
    logic [NV_W-1:0]    nv;
    logic [MAX_VCS-1:0] ready_m [MAX_SUBNETS];
    logic [VPW-1:0]     vp      [MAX_SUBNETS];
    logic [VPW-1:0]     pick_vc [MAX_SUBNETS];
    logic [MAX_SUBNETS-1:0] hit;
    logic               found;
    logic [SPW-1:0]     win_s;
    logic [VPW-1:0]     win_v;
    logic [SPW:0]       sp_inc;
    logic [VPW:0]       vp_inc;

    // Zero counts act as one, oversize counts as the built maximum
    assign ns = (active_subnets == '0) ? NS_W'(1) :
                (32'(active_subnets) > MAX_SUBNETS) ? NS_W'(MAX_SUBNETS) :
                NS_W'(active_subnets);
    assign nv = (active_vcs == '0) ? NV_W'(1) :
                (32'(active_vcs) > MAX_VCS) ? NV_W'(MAX_VCS) :
                NV_W'(active_vcs);

    for (genvar gs = 0; gs < MAX_SUBNETS; gs++) begin : g_sn
        assign vp[gs] = row_in[SPW + gs*VPW +: VPW];
        for (genvar gv = 0; gv < MAX_VCS; gv++) begin : g_vc
            if (gs * MAX_VCS + gv < MASK_W) begin : g_in
                assign ready_m[gs][gv] = pending_mask[gs * MAX_VCS + gv];
            end else begin : g_out
                assign ready_m[gs][gv] = 1'b0;
            end
        end
    end

    // Inner level: per subnet, first ready VC from its pointer
    always_comb begin
        logic [VPW-1:0] vc0;
        logic [VPW:0]   vsum;
        logic [VPW-1:0] vsel;
        for (int s = 0; s < MAX_SUBNETS; s++) begin
            vc0 = ((VPW+1)'(vp[s]) >= (VPW+1)'(nv)) ? '0 : vp[s];
            hit[s]     = 1'b0;
            pick_vc[s] = '0;
            for (int k = 0; k < MAX_VCS; k++) begin
                vsum = (VPW+1)'(vc0) + (VPW+1)'(k);
                if (vsum >= (VPW+1)'(nv)) begin
                    vsum = vsum - (VPW+1)'(nv);
                end
                vsel = VPW'(vsum);
                if (!hit[s] && (k < int'(nv)) && ready_m[s][vsel]) begin
                    hit[s]     = 1'b1;
                    pick_vc[s] = vsel;
                end
            end
        end
    end

    // Outer level: first subnet with a hit from the node's pointer
    always_comb begin
        logic [SPW-1:0] sn0;
        logic [SPW:0]   ssum;
        logic [SPW-1:0] ssel;
        sn0 = ((SPW+1)'(row_in[SPW-1:0]) >= (SPW+1)'(ns)) ? '0 : row_in[SPW-1:0];
        found = 1'b0;
        win_s = '0;
        win_v = '0;
        for (int k = 0; k < MAX_SUBNETS; k++) begin
            ssum = (SPW+1)'(sn0) + (SPW+1)'(k);
            if (ssum >= (SPW+1)'(ns)) begin
                ssum = ssum - (SPW+1)'(ns);
            end
            ssel = SPW'(ssum);
            if (!found && (k < int'(ns)) && hit[ssel]) begin
                found = 1'b1;
                win_s = ssel;
                win_v = pick_vc[ssel];
            end
        end
    end

    assign result.granted    = found && node_ok;
    assign result.win_subnet = result.granted ? SUBNET_W'(win_s) : '0;
    assign result.win_vc     = result.granted ? VC_W'(win_v) : '0;

    assign sp_inc = (SPW+1)'(win_s) + (SPW+1)'(1);
    assign vp_inc = (VPW+1)'(win_v) + (VPW+1)'(1);

    // Pointer row after a grant; other subnets keep their raw pointers
    always_comb begin
        row_out = row_in;
        if (result.granted) begin
            row_out[SPW-1:0] = (sp_inc == (SPW+1)'(ns)) ? '0 : SPW'(sp_inc);
            for (int s = 0; s < MAX_SUBNETS; s++) begin
                if (SPW'(s) == win_s) begin
                    row_out[SPW + s*VPW +: VPW] =
                        (vp_inc == (VPW+1)'(nv)) ? '0 : VPW'(vp_inc);
                end
            end
        end
    end

endmodule

`default_nettype wire
